### src/bapt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bapt_pkg
// Widths, register indexes and sideband types of the acceleration-phase
// time pipeline (signed Q16.16 positions and velocities, unsigned Q16.16 times).
// ----------------------------------------------------------------------------
package bapt_pkg;

    // word format
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // derived widths
    localparam int LIM_W  = WORD_BITS - 1;          // limit registers
    localparam int SQ_W   = 2 * LIM_W;              // square of a limit
    localparam int AV2_W  = 2 * LIM_W + 1;          // 2*A*V
    localparam int PROD_W = 2 * WORD_BITS;          // 32x32 products
    localparam int E_W    = 2 * WORD_BITS + 2;      // signed distance terms
    localparam int QUO_W  = WORD_BITS + FRAC_BITS;  // quotient bits per divider
    localparam int ROOT_W = WORD_BITS - 1;          // square root result
    localparam int RAD_W  = 2 * ROOT_W;             // square root radicand
    localparam int SUM_W  = QUO_W + 3;              // signed sum of three quotients

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_VELOCITY_LIMIT = 1'b0,
        REG_ACCEL_LIMIT    = 1'b1
    } cfg_idx_t;

    // values carried alongside the square root
    typedef struct packed {
        logic                  mirror;
        logic                  reach;
        logic                  ovs;
        logic                  sat3;
        logic [LIM_W-1:0]      uu;
        logic [WORD_BITS-1:0]  dv1;
        logic [PROD_W-1:0]     d3;
    } sq_side_t;

    localparam int SQ_SIDE_W = $bits(sq_side_t);

    // flags carried alongside the first divider
    typedef struct packed {
        logic neg2;
        logic ovs;
    } div_flags_t;

    localparam int FLAGS_W = $bits(div_flags_t);

endpackage

### src/bapt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bapt_in_if / bapt_out_if
// Valid/ready channels: one word per handshake.
// ----------------------------------------------------------------------------
interface bapt_in_if import bapt_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] position_delta;
    logic signed [WORD_BITS-1:0] start_velocity;

    modport source (output valid, output position_delta, output start_velocity, input ready);
    modport sink   (input valid, input position_delta, input start_velocity, output ready);
endinterface

interface bapt_out_if import bapt_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [WORD_BITS-1:0]        phase_time;
    logic signed [WORD_BITS-1:0] end_velocity;
    logic                        overshoot;

    modport source (output valid, output phase_time, output end_velocity, output overshoot,
                    input ready);
    modport sink   (input valid, input phase_time, input end_velocity, input overshoot,
                    output ready);
endinterface

### src/bounded_accel_phase_time_top.sv
`timescale 1ns / 1ps
// Path from input handshake to result word: 6 setup stages, 31-stage square
// root, 1 middle stage, 48-stage dividers, sum and output stages.
// Throughput: one word per cycle; the dividers and root take one bit a stage.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets both limits to 1.0.
// ----------------------------------------------------------------------------
// bounded_accel_phase_time_top
// Acceleration-phase time and end velocity of a trapezoidal profile for one
// axis, against configured speed and acceleration limits.
// ----------------------------------------------------------------------------
module bounded_accel_phase_time_top
    import bapt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  cfg_idx_t             cfg_index,
    input  logic [LIM_W-1:0]     cfg_wdata,
    bapt_in_if.sink              in_ch,
    bapt_out_if.source           out_ch
);

    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;

    // ---------------- configuration ----------------
    logic [LIM_W-1:0] v_lim_reg, a_lim_reg;
    logic [LIM_W-1:0] v_eff, a_eff;
    logic [SQ_W-1:0]  vsq_reg;
    logic [AV2_W-1:0] av2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_lim_reg <= LIM_W'(1) << F;
            a_lim_reg <= LIM_W'(1) << F;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VELOCITY_LIMIT: v_lim_reg <= cfg_wdata;
                REG_ACCEL_LIMIT:    a_lim_reg <= cfg_wdata;
            endcase
        end
    end

    // a zero limit acts as the smallest step
    assign v_eff = (v_lim_reg == '0) ? LIM_W'(1) : v_lim_reg;
    assign a_eff = (a_lim_reg == '0) ? LIM_W'(1) : a_lim_reg;

    // limit products, refreshed every cycle
    always_ff @(posedge clk)
    begin
        vsq_reg <= SQ_W'(v_eff) * SQ_W'(v_eff);
        av2_reg <= {SQ_W'(v_eff) * SQ_W'(a_eff), 1'b0};
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic out_valid_reg;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // ---------------- stage 1: mirror ----------------
    logic                s1_valid_reg, s1_mirror_reg;
    logic [W-1:0]        s1_pm_reg;
    logic signed [W:0]   s1_um_reg;
    logic                s1_mirror_next;
    logic [W-1:0]        s1_pm_next;
    logic signed [W:0]   s1_um_next;
    logic signed [W:0]   sv_ext;

    always_comb
    begin
        sv_ext         = $signed({in_ch.start_velocity[W-1], in_ch.start_velocity});
        s1_mirror_next = in_ch.position_delta[W-1] || (in_ch.position_delta == '0);
        s1_pm_next     = s1_mirror_next ? W'(-in_ch.position_delta) : W'(in_ch.position_delta);
        s1_um_next     = s1_mirror_next ? -sv_ext : sv_ext;
    end

    // ---------------- stage 2: products ----------------
    logic                s2_valid_reg, s2_mirror_reg, s2_brake_reg, s2_damp_reg;
    logic [PROD_W-1:0]   s2_e2_reg, s2_xsq_reg;
    logic [LIM_W-1:0]    s2_uu_reg;
    logic [W-1:0]        s2_dv1_reg;
    logic                s2_brake_next, s2_damp_next;
    logic [W-1:0]        mag, uu_raw, xval, s2_dv1_next;
    logic [PROD_W-1:0]   s2_e2_next, s2_xsq_next;
    logic [LIM_W-1:0]    s2_uu_next;

    always_comb
    begin
        s2_brake_next = s1_um_reg[W] || (s1_um_reg == '0);
        mag           = W'(-s1_um_reg);
        uu_raw        = s1_um_reg[W-1:0];
        s2_damp_next  = !s2_brake_next && (uu_raw > W'(v_eff));
        xval          = s2_brake_next ? mag : uu_raw;
        s2_xsq_next   = PROD_W'(xval) * PROD_W'(xval);
        s2_e2_next    = (PROD_W'(a_eff) * PROD_W'(s1_pm_reg)) << 1;
        if (s2_brake_next)
            s2_dv1_next = mag;
        else if (s2_damp_next)
            s2_dv1_next = uu_raw - W'(v_eff);
        else
            s2_dv1_next = '0;
        if (s2_brake_next)
            s2_uu_next = '0;
        else if (s2_damp_next)
            s2_uu_next = v_eff;
        else
            s2_uu_next = uu_raw[LIM_W-1:0];
    end

    // ---------------- stage 3: corrections ----------------
    logic                   s3_valid_reg, s3_mirror_reg;
    logic [PROD_W-1:0]      s3_e2_reg;
    logic signed [E_W-1:0]  s3_corr_reg;
    logic [SQ_W-1:0]        s3_uusq_reg, s3_g_reg;
    logic [LIM_W-1:0]       s3_uu_reg;
    logic [W-1:0]           s3_dv1_reg;
    logic signed [E_W-1:0]  s3_corr_next;
    logic [SQ_W-1:0]        s3_uusq_next, s3_g_next;

    always_comb
    begin
        if (s2_brake_reg)
            s3_corr_next = $signed(E_W'(s2_xsq_reg));
        else if (s2_damp_reg)
            s3_corr_next = $signed(E_W'(vsq_reg)) - $signed(E_W'(s2_xsq_reg));
        else
            s3_corr_next = '0;
        if (s2_damp_reg)
            s3_uusq_next = vsq_reg;
        else if (s2_brake_reg)
            s3_uusq_next = '0;
        else
            s3_uusq_next = s2_xsq_reg[SQ_W-1:0];
        s3_g_next = s2_damp_reg ? '0 : vsq_reg - s3_uusq_next;
    end

    // ---------------- stage 4: remaining distance ----------------
    logic                   s4_valid_reg, s4_mirror_reg;
    logic signed [E_W-1:0]  s4_e_reg;
    logic [SQ_W-1:0]        s4_uusq_reg, s4_g_reg;
    logic [LIM_W-1:0]       s4_uu_reg;
    logic [W-1:0]           s4_dv1_reg;
    logic signed [E_W-1:0]  s4_e_next;

    assign s4_e_next = $signed(E_W'(s3_e2_reg)) + s3_corr_reg;

    // ---------------- stage 5: case split ----------------
    logic                   s5_valid_reg, s5_mirror_reg, s5_reach_reg;
    logic signed [E_W-1:0]  s5_rsum_reg;
    logic [PROD_W-1:0]      s5_diff3_reg;
    logic [LIM_W-1:0]       s5_uu_reg;
    logic [W-1:0]           s5_dv1_reg;
    logic                   s5_reach_next;
    logic signed [E_W-1:0]  s5_rsum_next, s5_gap;

    always_comb
    begin
        s5_reach_next = $signed(E_W'(s4_g_reg)) > s4_e_reg;
        s5_rsum_next  = $signed(E_W'(s4_uusq_reg)) + s4_e_reg;
        s5_gap        = s4_e_reg - $signed(E_W'(s4_g_reg));
    end

    // ---------------- stage 6: clamp and overflow check ----------------
    logic                s6_valid_reg;
    logic [RAD_W-1:0]    s6_rad_reg;
    sq_side_t            s6_side_reg;
    logic [RAD_W-1:0]    s6_rad_next;
    sq_side_t            s6_side_next;
    logic                rsum_neg;

    always_comb
    begin
        rsum_neg            = s5_rsum_reg[E_W-1];
        s6_rad_next         = (s5_reach_reg && !rsum_neg) ? s5_rsum_reg[RAD_W-1:0] : '0;
        s6_side_next.mirror = s5_mirror_reg;
        s6_side_next.reach  = s5_reach_reg;
        s6_side_next.ovs    = s5_reach_reg && rsum_neg;
        s6_side_next.sat3   = !s5_reach_reg
                              && (AV2_W'(s5_diff3_reg[PROD_W-1:W]) >= av2_reg);
        s6_side_next.uu     = s5_uu_reg;
        s6_side_next.dv1    = s5_dv1_reg;
        s6_side_next.d3     = s5_reach_reg ? '0 : s5_diff3_reg;
    end

    // ---------------- stages 1 to 6 registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_ch.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mirror_reg <= s1_mirror_next;
            s1_pm_reg     <= s1_pm_next;
            s1_um_reg     <= s1_um_next;

            s2_mirror_reg <= s1_mirror_reg;
            s2_brake_reg  <= s2_brake_next;
            s2_damp_reg   <= s2_damp_next;
            s2_e2_reg     <= s2_e2_next;
            s2_xsq_reg    <= s2_xsq_next;
            s2_uu_reg     <= s2_uu_next;
            s2_dv1_reg    <= s2_dv1_next;

            s3_mirror_reg <= s2_mirror_reg;
            s3_e2_reg     <= s2_e2_reg;
            s3_corr_reg   <= s3_corr_next;
            s3_uusq_reg   <= s3_uusq_next;
            s3_g_reg      <= s3_g_next;
            s3_uu_reg     <= s2_uu_reg;
            s3_dv1_reg    <= s2_dv1_reg;

            s4_mirror_reg <= s3_mirror_reg;
            s4_e_reg      <= s4_e_next;
            s4_uusq_reg   <= s3_uusq_reg;
            s4_g_reg      <= s3_g_reg;
            s4_uu_reg     <= s3_uu_reg;
            s4_dv1_reg    <= s3_dv1_reg;

            s5_mirror_reg <= s4_mirror_reg;
            s5_reach_reg  <= s5_reach_next;
            s5_rsum_reg   <= s5_rsum_next;
            s5_diff3_reg  <= PROD_W'(s5_gap);
            s5_uu_reg     <= s4_uu_reg;
            s5_dv1_reg    <= s4_dv1_reg;

            s6_rad_reg    <= s6_rad_next;
            s6_side_reg   <= s6_side_next;
        end
    end

    // ---------------- square root ----------------
    logic                sq_valid;
    logic [ROOT_W-1:0]   sq_root;
    logic [SQ_SIDE_W-1:0] sq_side_bits;
    sq_side_t            sq_side;

    bapt_sqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .rad_in    (s6_rad_reg),
        .side_in   (s6_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side_bits)
    );

    assign sq_side = sq_side_t'(sq_side_bits);

    // ---------------- middle stage: second time term, end velocity ----------------
    logic               md_valid_reg, md_sat3_reg;
    logic [W-1:0]       md_dv1_reg, md_dv2_reg;
    logic [W-1:0]       md_endv_reg;
    logic [PROD_W-1:0]  md_d3_reg;
    div_flags_t         md_flags_reg;
    logic               goal_ge;
    logic [LIM_W-1:0]   md_dv2_next, end_mag;
    logic [W-1:0]       md_endv_next;
    div_flags_t         md_flags_next;

    always_comb
    begin
        goal_ge = (sq_root >= sq_side.uu);
        if (!sq_side.reach)
            md_dv2_next = v_eff - sq_side.uu;
        else if (goal_ge)
            md_dv2_next = sq_root - sq_side.uu;
        else
            md_dv2_next = sq_side.uu - sq_root;
        end_mag            = sq_side.reach ? sq_root : v_eff;
        md_endv_next       = sq_side.mirror ? ('0 - W'(end_mag)) : W'(end_mag);
        md_flags_next.neg2 = sq_side.reach && !goal_ge;
        md_flags_next.ovs  = sq_side.ovs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            md_valid_reg <= 1'b0;
        else if (en)
            md_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_dv1_reg   <= sq_side.dv1;
            md_dv2_reg   <= W'(md_dv2_next);
            md_endv_reg  <= md_endv_next;
            md_d3_reg    <= sq_side.d3;
            md_sat3_reg  <= sq_side.sat3;
            md_flags_reg <= md_flags_next;
        end
    end

    // ---------------- dividers ----------------
    logic               dv1_valid, dv2_valid, dv3_valid;
    logic [QUO_W-1:0]   q1, q2, q3;
    logic [FLAGS_W-1:0] q1_side;
    logic [W-1:0]       q2_side;
    logic               q3_side;
    div_flags_t         q_flags;

    // brake or damp term: dv1 / A
    bapt_div #(
        .DEN_W  (LIM_W),
        .Q_W    (QUO_W),
        .SIDE_W (FLAGS_W)
    ) u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (md_valid_reg),
        .rem_in    ('0),
        .work_in   ({md_dv1_reg, {F{1'b0}}}),
        .den       (a_eff),
        .side_in   (md_flags_reg),
        .out_valid (dv1_valid),
        .quo       (q1),
        .side_out  (q1_side)
    );

    // reach or accelerate-to-limit term: dv2 / A
    bapt_div #(
        .DEN_W  (LIM_W),
        .Q_W    (QUO_W),
        .SIDE_W (W)
    ) u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (md_valid_reg),
        .rem_in    ('0),
        .work_in   ({md_dv2_reg, {F{1'b0}}}),
        .den       (a_eff),
        .side_in   (md_endv_reg),
        .out_valid (dv2_valid),
        .quo       (q2),
        .side_out  (q2_side)
    );

    // cruise term: (E - G) / (2*A*V), high half preloaded as remainder
    bapt_div #(
        .DEN_W  (AV2_W),
        .Q_W    (QUO_W),
        .SIDE_W (1)
    ) u_div_cruise (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (md_valid_reg),
        .rem_in    (AV2_W'(md_d3_reg[PROD_W-1:W])),
        .work_in   ({md_d3_reg[W-1:0], {F{1'b0}}}),
        .den       (av2_reg),
        .side_in   (md_sat3_reg),
        .out_valid (dv3_valid),
        .quo       (q3),
        .side_out  (q3_side)
    );

    assign q_flags = div_flags_t'(q1_side);

    // ---------------- sum stage ----------------
    logic                    sm_valid_reg, sm_sat3_reg, sm_ovs_reg;
    logic signed [SUM_W-1:0] sm_total_reg;
    logic [W-1:0]            sm_endv_reg;
    logic signed [SUM_W-1:0] sm_total_next, t2_signed, t3_signed;

    always_comb
    begin
        t2_signed     = q_flags.neg2 ? -$signed(SUM_W'(q2)) : $signed(SUM_W'(q2));
        t3_signed     = q3_side ? '0 : $signed(SUM_W'(q3));
        sm_total_next = $signed(SUM_W'(q1)) + t2_signed + t3_signed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_valid_reg <= 1'b0;
        else if (en)
            sm_valid_reg <= dv2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_total_reg <= sm_total_next;
            sm_sat3_reg  <= q3_side;
            sm_ovs_reg   <= q_flags.ovs;
            sm_endv_reg  <= q2_side;
        end
    end

    // ---------------- output register: clamp to [0, max] ----------------
    logic [W-1:0] out_time_reg, out_endv_reg;
    logic         out_ovs_reg;
    logic [W-1:0] out_time_next;
    logic         too_big;

    always_comb
    begin
        too_big = sm_sat3_reg
                  || (!sm_total_reg[SUM_W-1] && (sm_total_reg[SUM_W-2:W] != '0));
        if (too_big)
            out_time_next = '1;
        else if (sm_total_reg[SUM_W-1])
            out_time_next = '0;
        else
            out_time_next = sm_total_reg[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= sm_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_time_reg <= out_time_next;
            out_endv_reg <= sm_endv_reg;
            out_ovs_reg  <= sm_ovs_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.phase_time   = out_time_reg;
    assign out_ch.end_velocity = out_endv_reg;
    assign out_ch.overshoot    = out_ovs_reg;

    // ---------------- assertions ----------------
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (dv1_valid == dv2_valid) && (dv3_valid == dv2_valid))
        else $error("dividers out of step");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> s1_valid_reg)
        else $error("accepted word missing from first stage");

    a_overshoot_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ovs_reg) |-> (out_endv_reg == '0))
        else $error("overshoot with nonzero end velocity");

    a_cruise_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (sm_valid_reg && en && sm_sat3_reg) |=> (out_time_reg == '1))
        else $error("cruise overflow not saturated");

endmodule

### src/bapt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bapt_div
// Pipelined restoring divider, one quotient bit per stage. The caller supplies
// the starting remainder (below den) and the remaining numerator bits, and
// must hold den constant while words are in flight; this is not checked.
// ----------------------------------------------------------------------------
module bapt_div #(
    parameter int DEN_W  = 31,
    parameter int Q_W    = 48,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  rem_in,
    input  logic [Q_W-1:0]    work_in,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    work_reg [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic [Q_W-1:0]    valid_reg;

    genvar k;
    for (k = 0; k < Q_W; k++)
    begin : g_step
        logic [DEN_W-1:0]  rem_prev;
        logic [Q_W-1:0]    work_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              valid_prev;
        logic [DEN_W:0]    cand;
        logic              take;
        logic [DEN_W-1:0]  rem_next;
        logic [Q_W-1:0]    work_next;

        if (k == 0)
        begin : g_first
            assign rem_prev   = rem_in;
            assign work_prev  = work_in;
            assign side_prev  = side_in;
            assign valid_prev = in_valid;
        end
        else
        begin : g_rest
            assign rem_prev   = rem_reg[k-1];
            assign work_prev  = work_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        always_comb
        begin
            cand      = {rem_prev, work_prev[Q_W-1]};
            take      = (cand >= {1'b0, den});
            rem_next  = take ? DEN_W'(cand - {1'b0, den}) : cand[DEN_W-1:0];
            work_next = {work_prev[Q_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                work_reg[k] <= work_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quo       = work_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

### src/bapt_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bapt_sqrt
// Pipelined integer square root (floor), one result bit per stage.
// ----------------------------------------------------------------------------
module bapt_sqrt #(
    parameter int ROOT_W = 31,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   rad_in,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     root,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int RAD_W = 2 * ROOT_W;

    logic [ROOT_W:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];
    logic [RAD_W-1:0]   rad_reg  [ROOT_W];
    logic [SIDE_W-1:0]  side_reg [ROOT_W];
    logic [ROOT_W-1:0]  valid_reg;

    genvar k;
    for (k = 0; k < ROOT_W; k++)
    begin : g_step
        logic [ROOT_W:0]    rem_prev;
        logic [ROOT_W-1:0]  root_prev;
        logic [RAD_W-1:0]   rad_prev;
        logic [SIDE_W-1:0]  side_prev;
        logic               valid_prev;
        logic [ROOT_W+2:0]  cand;
        logic [ROOT_W+2:0]  trial;
        logic               take;
        logic [ROOT_W:0]    rem_next;
        logic [ROOT_W-1:0]  root_next;
        logic [RAD_W-1:0]   rad_next;

        if (k == 0)
        begin : g_first
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign rad_prev   = rad_in;
            assign side_prev  = side_in;
            assign valid_prev = in_valid;
        end
        else
        begin : g_rest
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign rad_prev   = rad_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        always_comb
        begin
            cand      = {rem_prev, rad_prev[RAD_W-1 -: 2]};
            trial     = {1'b0, root_prev, 2'b01};
            take      = (cand >= trial);
            rem_next  = take ? (ROOT_W+1)'(cand - trial) : cand[ROOT_W:0];
            root_next = {root_prev[ROOT_W-2:0], take};
            rad_next  = {rad_prev[RAD_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the acceleration-phase time pipeline. A clocked
// driver feeds position/velocity words from a queue with optional random gaps, and a
// clocked monitor compares every result word with a bit-exact prediction of
// phase time, end velocity and the overshoot flag. The limits are changed
// between phases while the pipeline is empty, including zero and full-scale.
// ----------------------------------------------------------------------------
module tb_top
    import bapt_pkg::*;
();

    localparam int PIPE_LAT = 88;

    typedef logic signed [129:0] wide_t;

    typedef struct {
        logic signed [WORD_BITS-1:0] pos;
        logic signed [WORD_BITS-1:0] vel;
    } motion_word_t;

    typedef struct {
        logic [WORD_BITS-1:0]        ptime;
        logic signed [WORD_BITS-1:0] vend;
        logic                        ovs;
    } profile_word_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [LIM_W-1:0] cfg_wdata;

    bapt_in_if  in_ch ();
    bapt_out_if out_ch ();

    bounded_accel_phase_time_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // bench copy of the limit registers
    logic [LIM_W-1:0] vel_limit;
    logic [LIM_W-1:0] acc_limit;

    motion_word_t  motion_q[$];
    profile_word_t profile_q[$];
    motion_word_t  cur_word;

    int  err_count;
    int  words_in;
    int  words_out;
    int  ovs_seen;
    int  sat_seen;
    int  send_gap;
    int  recv_gap;
    int  hold_stall;
    bit  taken;
    bit  gaps_on;

    // ---------------------------------------------------------------
    // clock
    // ---------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // floor square root, radicand below 2^64
    // ---------------------------------------------------------------
    function automatic wide_t floor_root(input wide_t rad);
        wide_t res;
        wide_t t;
        res = 0;
        for (int b = 32; b >= 0; b--)
        begin
            t = res | (wide_t'(1) <<< b);
            if (t * t <= rad)
                res = t;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // expected phase time / end velocity for one motion word
    // ---------------------------------------------------------------
    function automatic profile_word_t accel_phase(input motion_word_t w);
        profile_word_t r;
        wide_t vl, al, p, u, uu, e, g, total, rad, goal, tmax;
        bit    mirror;
        vl = (vel_limit == 0) ? 1 : wide_t'({1'b0, vel_limit});
        al = (acc_limit == 0) ? 1 : wide_t'({1'b0, acc_limit});
        p  = wide_t'(w.pos);
        u  = wide_t'(w.vel);
        mirror = (p <= 0);
        r.ovs = 1'b0;
        total = 0;
        if (mirror)
        begin
            p = -p;
            u = -u;
        end
        e = 2 * al * p;
        // brake to zero
        if (u <= 0)
        begin
            total = total + (((-u) <<< FRAC_BITS) / al);
            e = e + u * u;
            uu = 0;
        end
        else
            uu = u;
        g = vl * vl - uu * uu;
        // damp down to the limit
        if (g < 0)
        begin
            e = e + g;
            total = total + (((uu - vl) <<< FRAC_BITS) / al);
            uu = vl;
            g = 0;
        end
        if (g > e)
        begin
            // pure acceleration
            rad = uu * uu + e;
            if (rad < 0)
            begin
                rad = 0;
                r.ovs = 1'b1;
            end
            goal = floor_root(rad);
            if (goal >= uu)
                total = total + (((goal - uu) <<< FRAC_BITS) / al);
            else
                total = total - (((uu - goal) <<< FRAC_BITS) / al);
        end
        else
        begin
            // accelerate then cruise
            total = total + (((vl - uu) <<< FRAC_BITS) / al);
            total = total + (((e - g) <<< FRAC_BITS) / (2 * al * vl));
            goal = vl;
        end
        tmax = (wide_t'(1) <<< WORD_BITS) - 1;
        if (total < 0)
            r.ptime = '0;
        else if (total > tmax)
            r.ptime = '1;
        else
            r.ptime = total[WORD_BITS-1:0];
        r.vend = mirror ? WORD_BITS'(-goal) : WORD_BITS'(goal);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("%0t: mismatch on %s word %0d: got %h, want %h",
                 $realtime, what, words_out, got, want);
    endtask

    // ---------------------------------------------------------------
    // input acceptance and result check, rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        profile_word_t want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            cur_word.pos = in_ch.position_delta;
            cur_word.vel = in_ch.start_velocity;
            profile_q.push_back(accel_phase(cur_word));
            words_in++;
            taken = 1'b1;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (profile_q.size() == 0)
            begin
                err_count++;
                $display("%0t: result word with nothing expected", $realtime);
            end
            else
            begin
                want = profile_q.pop_front();
                if (out_ch.phase_time !== want.ptime)
                    report_mismatch("phase_time", out_ch.phase_time, want.ptime);
                if (out_ch.end_velocity !== want.vend)
                    report_mismatch("end_velocity", out_ch.end_velocity, want.vend);
                if (out_ch.overshoot !== want.ovs)
                    report_mismatch("overshoot", out_ch.overshoot, want.ovs);
                if (want.ovs)
                    ovs_seen++;
                if (want.ptime == '1)
                    sat_seen++;
            end
            words_out++;
            recv_gap = gaps_on ? $urandom_range(0, 3) : 0;
        end
    end

    // ---------------------------------------------------------------
    // driver, falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        motion_word_t w;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!(in_ch.valid && !taken))
        begin
            taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (motion_q.size() > 0)
            begin
                w = motion_q.pop_front();
                in_ch.position_delta <= w.pos;
                in_ch.start_velocity <= w.vel;
                in_ch.valid <= 1'b1;
                send_gap = gaps_on ? $urandom_range(0, 3) : 0;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver back-pressure, falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_stall > 0)
        begin
            hold_stall--;
            out_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic signed [31:0] any_word();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $signed($urandom >> $urandom_range(8, 31));
            2: v = -$signed($urandom >> $urandom_range(8, 31));
            3: v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            4: v = $signed($urandom_range(0, 3)) - 2;
            default: v = $signed($urandom >> $urandom_range(1, 16));
        endcase
        return v;
    endfunction

    // velocity near the limit, either side, either sign
    function automatic logic signed [31:0] near_limit();
        longint v;
        v = vel_limit + $signed($urandom_range(0, 64)) - 32;
        if ($urandom_range(0, 1))
            v = v + ($urandom >> $urandom_range(4, 31));
        if (v > 64'sh7fffffff)
            v = 64'sh7fffffff;
        return $urandom_range(0, 1) ? 32'(v) : 32'(-v);
    endfunction

    task automatic queue_word(input logic signed [31:0] pos,
                              input logic signed [31:0] vel);
        motion_word_t w;
        w.pos = pos;
        w.vel = vel;
        motion_q.push_back(w);
    endtask

    task automatic queue_random(input int n);
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        for (int i = 0; i < n; i++)
        begin
            pos = any_word();
            vel = $urandom_range(0, 2) == 0 ? near_limit() : any_word();
            // small distance with high speed toward the goal gives overshoot
            if ($urandom_range(0, 5) == 0)
            begin
                pos = $signed($urandom >> $urandom_range(12, 31));
                vel = 32'sh7fffffff - $signed($urandom >> $urandom_range(1, 31));
                if ($urandom_range(0, 1))
                begin
                    pos = -pos;
                    vel = -vel;
                end
            end
            queue_word(pos, vel);
        end
    endtask

    task automatic drain();
        while (motion_q.size() > 0 || in_ch.valid || profile_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_limits(input logic [LIM_W-1:0] vl, input logic [LIM_W-1:0] al);
        drain();
        repeat (PIPE_LAT + 8) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VELOCITY_LIMIT;
        cfg_wdata <= vl;
        @(negedge clk);
        cfg_index <= REG_ACCEL_LIMIT;
        cfg_wdata <= al;
        @(negedge clk);
        cfg_we <= 1'b0;
        vel_limit = vl;
        acc_limit = al;
    endtask

    // ---------------------------------------------------------------
    // run
    // ---------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_VELOCITY_LIMIT;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.position_delta = '0;
        in_ch.start_velocity = '0;
        out_ch.ready = 1'b0;
        vel_limit  = LIM_W'(1 << FRAC_BITS);
        acc_limit  = LIM_W'(1 << FRAC_BITS);
        err_count  = 0;
        words_in   = 0;
        words_out  = 0;
        ovs_seen   = 0;
        sat_seen   = 0;
        send_gap   = 0;
        recv_gap   = 0;
        hold_stall = 0;
        taken      = 1'b0;
        gaps_on    = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words at reset limits (1.0 / 1.0)
        queue_word(0, 0);
        queue_word(0, 32'sh00010000);
        queue_word(32'sh7fffffff, 32'sh7fffffff);
        queue_word(32'sh7fffffff, 32'sh80000000);
        queue_word(32'sh80000000, 32'sh80000000);
        queue_word(32'sh80000000, 32'sh7fffffff);
        queue_word(32'sh00010000, 0);
        queue_word(-32'sh00010000, 0);
        queue_word(32'sh00010000, -32'sh00020000);
        queue_word(32'sh00000001, 32'sh00030000);
        queue_word(-32'sh00000001, -32'sh00030000);
        queue_word(32'sh00100000, 32'sh00020000);
        queue_word(32'sh00100000, 32'sh00008000);
        queue_word(32'sh00000100, 32'sh00008000);
        queue_word(32'sh00010000, 32'sh00010000);
        queue_word(1, -1);
        queue_word(-1, 1);
        queue_word(32'sh55555555, 32'shaaaaaaaa);
        queue_word(32'shaaaaaaaa, 32'sh55555555);
        queue_random(40);

        // sender pause until everything is back, then mixed traffic
        drain();
        gaps_on = 1'b0;
        queue_random(30);
        drain();
        gaps_on = 1'b1;

        // full-scale limits, then long receiver stall with no gaps
        write_limits('1, '1);
        queue_random(40);
        drain();
        gaps_on = 1'b0;
        hold_stall = 300;
        queue_random(150);
        drain();
        gaps_on = 1'b1;

        // smallest limits, and zero limits read as one step
        write_limits(1, 1);
        queue_random(40);
        write_limits('0, '0);
        queue_random(30);
        write_limits(LIM_W'(32'h0003_8000), LIM_W'(32'h0000_0400));
        queue_random(40);
        write_limits(LIM_W'(32'h0000_0200), '1);
        queue_random(30);
        write_limits(LIM_W'(32'h0010_0000), LIM_W'(32'h0002_0000));
        queue_random(40);
        drain();
        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("tb summary: %0d words in, %0d out over 7 limit settings", words_in, words_out);
        $display("tb summary: %0d overshoot and %0d saturated results seen", ovs_seen, sat_seen);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
src/bapt_pkg.sv
src/bapt_ifs.sv
src/bapt_div.sv
src/bapt_sqrt.sv
src/bounded_accel_phase_time_top.sv
dv/tb_top.sv
